>>> rtl/lcsu_pkg.sv
package lcsu_pkg;

    // default capacities of the two strings
    localparam int DEF_MAX_FIRST  = 32;
    localparam int DEF_MAX_SECOND = 32;

    // fixed field widths
    localparam int SYM_W  = 8;
    localparam int CMD_W  = 2;
    localparam int LEN_W  = 6;

    // command codes carried in s_tuser
    localparam logic [CMD_W-1:0] CMD_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

    // direction mark kept per table cell
    typedef enum logic [1:0] {
        DIR_DIAG = 2'd1,
        DIR_LEFT = 2'd2,
        DIR_UP   = 2'd3
    } dir_t;

    // controller to datapath
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic run_start;
        logic row_start;
        logic cell_issue;
        logic row_next;
        logic trace_start;
        logic trace_step;
        logic emit_start;
        logic out_load;
        logic emit_next;
        logic clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic both_nonzero;
        logic last_col;
        logic last_row;
        logic trace_end;
        logic emit_last;
    } stat_t;

endpackage

>>> rtl/longest_common_subsequence_unit.sv
// longest common subsequence of two byte strings. each input transfer carries a command in
// s_tuser: 0 appends s_tdata to the first string, 1 appends it to the second, 2 computes the
// subsequence and streams it out first to last, one result transfer per symbol with m_tlast on
// the final one; an empty result gives a single transfer with symbol_valid low. symbols past a
// string's capacity are dropped and reported through overflowed; both strings are cleared after
// the last result transfer. the block stays ready for input after each load. a compute fills the
// table one cell per cycle within a row, through the length-row memory, then traces back (at
// most m+n steps for an m by n pair, one direction-memory read each), then sends each result
// transfer through a buffer read, an output-register load and a wait for m_tready. no input is
// taken during a compute. no clearing pass is needed after reset.
module longest_common_subsequence_unit #(
    parameter int MAX_FIRST  = lcsu_pkg::DEF_MAX_FIRST,
    parameter int MAX_SECOND = lcsu_pkg::DEF_MAX_SECOND
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] symbol_res, [13:8] lcs_length, [15:14] zero
    output logic [1:0]  m_tuser,   // [0] symbol_valid, [1] overflowed
    output logic        m_tlast
);

    lcsu_pkg::cmd_t  cmd;
    lcsu_pkg::stat_t stat;

    logic [lcsu_pkg::SYM_W-1:0] symbol_res;
    logic                       symbol_valid;
    logic [lcsu_pkg::LEN_W-1:0] lcs_length;
    logic                       overflowed;

    // sequencer: load, fill, traceback and emit phases
    lcsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // string stores, table fill cell, direction table, result buffer and output register
    lcsu_datapath #(
        .MAX_FIRST  (MAX_FIRST),
        .MAX_SECOND (MAX_SECOND)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .symbol_in    (s_tdata),
        .stat         (stat),
        .symbol_res   (symbol_res),
        .symbol_valid (symbol_valid),
        .lcs_length   (lcs_length),
        .overflowed   (overflowed),
        .last         (m_tlast)
    );

    assign m_tdata = {2'b00, lcs_length, symbol_res};
    assign m_tuser = {overflowed, symbol_valid};

`ifndef SYNTH
    // input and result sides never overlap in this sequential design
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // a compute transfer closes the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == lcsu_pkg::CMD_RUN)) |=> !s_tready)
        else $error("input still ready after compute transfer");

    // append transfers cause no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser != lcsu_pkg::CMD_RUN)) |=> (s_tready && !m_tvalid))
        else $error("append transfer left idle state");

    // last result transfer returns the block to accepting input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready for input after final result");

    // an empty result is always a single final transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata[13:8] == '0)))
        else $error("empty result not marked last");
`endif

endmodule

>>> rtl/lcsu_datapath.sv
module lcsu_datapath #(
    parameter int MAX_FIRST  = lcsu_pkg::DEF_MAX_FIRST,
    parameter int MAX_SECOND = lcsu_pkg::DEF_MAX_SECOND
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lcsu_pkg::cmd_t             cmd,
    input  logic [lcsu_pkg::SYM_W-1:0] symbol_in,
    output lcsu_pkg::stat_t            stat,
    output logic [lcsu_pkg::SYM_W-1:0] symbol_res,
    output logic                       symbol_valid,
    output logic [lcsu_pkg::LEN_W-1:0] lcs_length,
    output logic                       overflowed,
    output logic                       last
);

    localparam int FA        = (MAX_FIRST > 1) ? $clog2(MAX_FIRST) : 1;
    localparam int SA        = (MAX_SECOND > 1) ? $clog2(MAX_SECOND) : 1;
    localparam int FC        = $clog2(MAX_FIRST + 1);
    localparam int SC        = $clog2(MAX_SECOND + 1);
    localparam int LW        = SC;
    localparam int DIR_DEPTH = 2 ** (FA + SA);

    // memories
    logic [lcsu_pkg::SYM_W-1:0] first_str_reg  [MAX_FIRST];
    logic [lcsu_pkg::SYM_W-1:0] second_str_reg [MAX_SECOND];
    logic [LW-1:0]              row_mem_reg    [MAX_SECOND];
    lcsu_pkg::dir_t             dir_mem_reg    [DIR_DEPTH];
    logic [lcsu_pkg::SYM_W-1:0] rev_mem_reg    [MAX_FIRST];

    logic [lcsu_pkg::SYM_W-1:0] first_rd_reg;
    logic [lcsu_pkg::SYM_W-1:0] second_rd_reg;
    logic [LW-1:0]              row_rd_reg;
    lcsu_pkg::dir_t             dir_rd_reg;
    logic [lcsu_pkg::SYM_W-1:0] rev_rd_reg;

    // counters and indexes
    logic [FC-1:0] first_cnt_reg;
    logic [SC-1:0] second_cnt_reg;
    logic          ovf_reg;
    logic [FA-1:0] ri_reg;
    logic [SA-1:0] ci_reg;
    logic          p_valid_reg;
    logic [SA-1:0] p_ci_reg;
    logic [LW-1:0] diag_reg;
    logic [LW-1:0] left_reg;
    logic [FC-1:0] nres_reg;
    logic [FA-1:0] e_reg;

    // output register
    logic [lcsu_pkg::SYM_W-1:0] sym_out_reg;
    logic                       sval_out_reg;
    logic [lcsu_pkg::LEN_W-1:0] len_out_reg;
    logic                       ovf_out_reg;
    logic                       last_out_reg;

    logic           first_full;
    logic           second_full;
    logic [LW-1:0]  up_val;
    logic [LW-1:0]  cell_val;
    lcsu_pkg::dir_t cell_dir;
    logic           len_zero;
    logic           is_diag;

    assign first_full  = (first_cnt_reg == FC'(MAX_FIRST));
    assign second_full = (second_cnt_reg == SC'(MAX_SECOND));
    assign len_zero    = (nres_reg == '0);
    assign is_diag     = (dir_rd_reg == lcsu_pkg::DIR_DIAG);

    // the first row of the table sees zeros above
    assign up_val = (ri_reg == '0) ? '0 : row_rd_reg;

    always_comb begin
        if (first_rd_reg == second_rd_reg) begin
            cell_val = LW'(diag_reg + 1'b1);
            cell_dir = lcsu_pkg::DIR_DIAG;
        end else if (left_reg > up_val) begin
            cell_val = left_reg;
            cell_dir = lcsu_pkg::DIR_LEFT;
        end else begin
            cell_val = up_val;
            cell_dir = lcsu_pkg::DIR_UP;
        end
    end

    always_comb begin
        stat.both_nonzero = (first_cnt_reg != '0) && (second_cnt_reg != '0);
        stat.last_col     = (ci_reg == SA'(second_cnt_reg - 1'b1));
        stat.last_row     = (ri_reg == FA'(first_cnt_reg - 1'b1));
        stat.emit_last    = last_out_reg;
        case (dir_rd_reg)
            lcsu_pkg::DIR_DIAG: stat.trace_end = (ri_reg == '0) || (ci_reg == '0);
            lcsu_pkg::DIR_LEFT: stat.trace_end = (ci_reg == '0);
            default:            stat.trace_end = (ri_reg == '0);
        endcase
    end

    // string stores, read at the current row and column
    always_ff @(posedge aclk) begin
        if (cmd.load_first && !first_full) begin
            first_str_reg[first_cnt_reg[FA-1:0]] <= symbol_in;
        end
        if (cmd.load_second && !second_full) begin
            second_str_reg[second_cnt_reg[SA-1:0]] <= symbol_in;
        end
        first_rd_reg  <= first_str_reg[ri_reg];
        second_rd_reg <= second_str_reg[ci_reg];
    end

    // length row and direction table
    always_ff @(posedge aclk) begin
        if (p_valid_reg) begin
            row_mem_reg[p_ci_reg]           <= cell_val;
            dir_mem_reg[{ri_reg, p_ci_reg}] <= cell_dir;
        end
        row_rd_reg <= row_mem_reg[ci_reg];
        dir_rd_reg <= dir_mem_reg[{ri_reg, ci_reg}];
    end

    // subsequence collected last to first
    always_ff @(posedge aclk) begin
        if (cmd.trace_step && is_diag) begin
            rev_mem_reg[nres_reg[FA-1:0]] <= first_rd_reg;
        end
        rev_rd_reg <= rev_mem_reg[e_reg];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            ovf_reg        <= 1'b0;
            p_valid_reg    <= 1'b0;
        end else begin
            p_valid_reg <= cmd.cell_issue;
            if (cmd.clear) begin
                first_cnt_reg  <= '0;
                second_cnt_reg <= '0;
                ovf_reg        <= 1'b0;
            end else begin
                if (cmd.load_first) begin
                    if (first_full) ovf_reg <= 1'b1;
                    else first_cnt_reg <= first_cnt_reg + 1'b1;
                end
                if (cmd.load_second) begin
                    if (second_full) ovf_reg <= 1'b1;
                    else second_cnt_reg <= second_cnt_reg + 1'b1;
                end
            end
        end
    end

    // indexes, cell pipeline and result counters
    always_ff @(posedge aclk) begin
        if (cmd.run_start) begin
            ri_reg   <= '0;
            nres_reg <= '0;
        end
        if (cmd.row_start) begin
            ci_reg   <= '0;
            diag_reg <= '0;
            left_reg <= '0;
        end
        if (cmd.cell_issue) begin
            ci_reg   <= ci_reg + 1'b1;
            p_ci_reg <= ci_reg;
        end
        if (p_valid_reg) begin
            left_reg <= cell_val;
            diag_reg <= up_val;
        end
        if (cmd.row_next) begin
            ri_reg <= ri_reg + 1'b1;
        end
        if (cmd.trace_start) begin
            ri_reg <= FA'(first_cnt_reg - 1'b1);
            ci_reg <= SA'(second_cnt_reg - 1'b1);
        end
        if (cmd.trace_step) begin
            case (dir_rd_reg)
                lcsu_pkg::DIR_DIAG: begin
                    nres_reg <= nres_reg + 1'b1;
                    ri_reg   <= ri_reg - 1'b1;
                    ci_reg   <= ci_reg - 1'b1;
                end
                lcsu_pkg::DIR_LEFT: begin
                    ci_reg <= ci_reg - 1'b1;
                end
                default: begin
                    ri_reg <= ri_reg - 1'b1;
                end
            endcase
        end
        if (cmd.emit_start) begin
            e_reg <= FA'(nres_reg - 1'b1);
        end
        if (cmd.emit_next) begin
            e_reg <= e_reg - 1'b1;
        end
        if (cmd.out_load) begin
            sym_out_reg  <= len_zero ? '0 : rev_rd_reg;
            sval_out_reg <= !len_zero;
            len_out_reg  <= lcsu_pkg::LEN_W'(nres_reg);
            ovf_out_reg  <= ovf_reg;
            last_out_reg <= len_zero || (e_reg == '0);
        end
    end

    assign symbol_res   = sym_out_reg;
    assign symbol_valid = sval_out_reg;
    assign lcs_length   = len_out_reg;
    assign overflowed   = ovf_out_reg;
    assign last         = last_out_reg;

endmodule

>>> rtl/lcsu_ctrl.sv
module lcsu_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic [lcsu_pkg::CMD_W-1:0] s_cmd,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  lcsu_pkg::stat_t            stat,
    output lcsu_pkg::cmd_t             cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_CELL,
        ST_ROW_END,
        ST_TR_READ,
        ST_TR_STEP,
        ST_EM_INIT,
        ST_EM_READ,
        ST_EM_LOAD,
        ST_EM_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_first  = (s_cmd == lcsu_pkg::CMD_FIRST);
                    cmd.load_second = (s_cmd == lcsu_pkg::CMD_SECOND);
                    if (s_cmd == lcsu_pkg::CMD_RUN) begin
                        cmd.run_start = 1'b1;
                        state_next    = stat.both_nonzero ? ST_ROW : ST_EM_INIT;
                    end
                end
            end
            ST_ROW: begin
                cmd.row_start = 1'b1;
                state_next    = ST_CELL;
            end
            ST_CELL: begin
                cmd.cell_issue = 1'b1;
                if (stat.last_col) state_next = ST_ROW_END;
            end
            ST_ROW_END: begin
                if (stat.last_row) begin
                    cmd.trace_start = 1'b1;
                    state_next      = ST_TR_READ;
                end else begin
                    cmd.row_next = 1'b1;
                    state_next   = ST_ROW;
                end
            end
            ST_TR_READ: begin
                state_next = ST_TR_STEP;
            end
            ST_TR_STEP: begin
                cmd.trace_step = 1'b1;
                state_next     = stat.trace_end ? ST_EM_INIT : ST_TR_READ;
            end
            ST_EM_INIT: begin
                cmd.emit_start = 1'b1;
                state_next     = ST_EM_READ;
            end
            ST_EM_READ: begin
                state_next = ST_EM_LOAD;
            end
            ST_EM_LOAD: begin
                cmd.out_load  = 1'b1;
                m_tvalid_next = 1'b1;
                state_next    = ST_EM_WAIT;
            end
            ST_EM_WAIT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (stat.emit_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_EM_READ;
                    end
                end
            end
            default: begin
                state_next    = ST_IDLE;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule
